// ===== design/pvadd_pkg.sv =====
// Package for the polar vector adder: beat types, pipeline word types,
// number formats and the CORDIC arctangent table. Depends on nothing.
package pvadd_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int MAX_STAGES        = 24;

   // Datapath widths: lengths in Q16.14 with headroom for the CORDIC gain
   // of both passes, angles in 32-bit turns with two guard bits.
   localparam int XW = 36;
   localparam int ZW = 34;

   localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sh4000_0000);
   localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sh8000_0000);
   localparam logic [30:0]          GAIN_COMP    = 31'd1583795508;
   localparam logic [16:0]          LEN_MAX      = 17'h1_FFFF;

   typedef struct packed {
      logic signed [15:0] angle_a;
      logic        [15:0] length_a;
      logic signed [15:0] angle_b;
      logic        [15:0] length_b;
   } req_type;

   typedef struct packed {
      logic        [16:0] sum_length;
      logic signed [15:0] sum_angle;
   } rsp_type;

   typedef struct packed {
      logic signed [XW-1:0] x_a;
      logic signed [XW-1:0] y_a;
      logic signed [ZW-1:0] z_a;
      logic signed [XW-1:0] x_b;
      logic signed [XW-1:0] y_b;
      logic signed [ZW-1:0] z_b;
   } rot_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } vec_type;

   // round(2^32 * atan(2^-i) / (2*pi)); entries past the table read as zero.
   function automatic logic [31:0] atan_entry(input int unsigned idx);
      logic [31:0] val;
      unique case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10679838;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== design/pvadd_rot_cell.sv =====
// One rotation-mode CORDIC cell, stepping both input vectors at once.
// Depends on pvadd_pkg.
module pvadd_rot_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pvadd_pkg::rot_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output pvadd_pkg::rot_type out_data
);

   localparam logic signed [pvadd_pkg::ZW-1:0] ATAN =
      pvadd_pkg::ZW'(pvadd_pkg::atan_entry(IDX));

   logic               valid_ff;
   pvadd_pkg::rot_type data_ff;
   pvadd_pkg::rot_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in = in_data;
      if (!in_data.z_a[pvadd_pkg::ZW-1]) begin
         data_in.x_a = in_data.x_a - (in_data.y_a >>> IDX);
         data_in.y_a = in_data.y_a + (in_data.x_a >>> IDX);
         data_in.z_a = in_data.z_a - ATAN;
      end else begin
         data_in.x_a = in_data.x_a + (in_data.y_a >>> IDX);
         data_in.y_a = in_data.y_a - (in_data.x_a >>> IDX);
         data_in.z_a = in_data.z_a + ATAN;
      end
      if (!in_data.z_b[pvadd_pkg::ZW-1]) begin
         data_in.x_b = in_data.x_b - (in_data.y_b >>> IDX);
         data_in.y_b = in_data.y_b + (in_data.x_b >>> IDX);
         data_in.z_b = in_data.z_b - ATAN;
      end else begin
         data_in.x_b = in_data.x_b + (in_data.y_b >>> IDX);
         data_in.y_b = in_data.y_b - (in_data.x_b >>> IDX);
         data_in.z_b = in_data.z_b + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== design/pvadd_vec_cell.sv =====
// One vectoring-mode CORDIC cell, driving y of the summed vector to zero.
// Depends on pvadd_pkg.
module pvadd_vec_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pvadd_pkg::vec_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output pvadd_pkg::vec_type out_data
);

   localparam logic signed [pvadd_pkg::ZW-1:0] ATAN =
      pvadd_pkg::ZW'(pvadd_pkg::atan_entry(IDX));

   logic               valid_ff;
   pvadd_pkg::vec_type data_ff;
   pvadd_pkg::vec_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      if (in_data.y[pvadd_pkg::XW-1]) begin
         data_in.x = in_data.x - (in_data.y >>> IDX);
         data_in.y = in_data.y + (in_data.x >>> IDX);
         data_in.z = in_data.z - ATAN;
      end else begin
         data_in.x = in_data.x + (in_data.y >>> IDX);
         data_in.y = in_data.y - (in_data.x >>> IDX);
         data_in.z = in_data.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== design/polar_vector_adder.sv =====
// Top level of the polar vector adder: rotation cells, vector sum,
// vectoring cells and gain correction. Depends on pvadd_pkg and both cells.
//
//  Channel   Ports                        Direction  Beat contents
//  request   req_valid req_stall req_data in         two polar vectors
//  response  rsp_valid rsp_stall rsp_data out        polar vector sum
//
// One beat enters per cycle and one leaves per cycle, sustained while
// rsp_stall is low, through a quadrant stage, CORDIC_STAGES rotation cells,
// the summing stage, CORDIC_STAGES vectoring cells, a split multiply stage
// and the output register. Reset clears only the valid flags of the stages.
// Every stage holds its beat while the one after it is full and stalled, so
// bubbles close up and the request side stalls only when all stages are full.
module polar_vector_adder #(
   parameter int CORDIC_STAGES = pvadd_pkg::CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pvadd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pvadd_pkg::rsp_type rsp_data
);

   localparam int XW = pvadd_pkg::XW;
   localparam int ZW = pvadd_pkg::ZW;

   // ---------------------------------------------------------------------
   // Quadrant stage: turn the angle into 32-bit turns and the length into
   // Q16.14, folding angles beyond a quarter turn into the right half plane.
   // ---------------------------------------------------------------------
   logic               pre_valid_ff;
   logic               pre_ready;
   pvadd_pkg::rot_type pre_ff;
   pvadd_pkg::rot_type pre_in;

   logic               rot_valid [0:CORDIC_STAGES];
   logic               rot_ready [0:CORDIC_STAGES];
   pvadd_pkg::rot_type rot_data  [0:CORDIC_STAGES];

   always_comb begin
      pre_in.z_a = {{(ZW-32){req_data.angle_a[15]}}, req_data.angle_a, 16'b0};
      pre_in.x_a = {{(XW-30){1'b0}}, req_data.length_a, 14'b0};
      pre_in.y_a = '0;
      pre_in.z_b = {{(ZW-32){req_data.angle_b[15]}}, req_data.angle_b, 16'b0};
      pre_in.x_b = {{(XW-30){1'b0}}, req_data.length_b, 14'b0};
      pre_in.y_b = '0;
      if (pre_in.z_a > pvadd_pkg::QUARTER_TURN) begin
         pre_in.x_a = -pre_in.x_a;
         pre_in.z_a = pre_in.z_a - pvadd_pkg::HALF_TURN;
      end else if (pre_in.z_a < -pvadd_pkg::QUARTER_TURN) begin
         pre_in.x_a = -pre_in.x_a;
         pre_in.z_a = pre_in.z_a + pvadd_pkg::HALF_TURN;
      end
      if (pre_in.z_b > pvadd_pkg::QUARTER_TURN) begin
         pre_in.x_b = -pre_in.x_b;
         pre_in.z_b = pre_in.z_b - pvadd_pkg::HALF_TURN;
      end else if (pre_in.z_b < -pvadd_pkg::QUARTER_TURN) begin
         pre_in.x_b = -pre_in.x_b;
         pre_in.z_b = pre_in.z_b + pvadd_pkg::HALF_TURN;
      end
   end

   assign pre_ready = !pre_valid_ff || rot_ready[0];
   assign req_stall = !pre_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (pre_ready) begin
         pre_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pre_ready && req_valid) begin
         pre_ff <= pre_in;
      end
   end

   assign rot_valid[0] = pre_valid_ff;
   assign rot_data[0]  = pre_ff;

   // ---------------------------------------------------------------------
   // Rotation chain: one cell per CORDIC step, both vectors side by side.
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      pvadd_rot_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (rot_valid[i]),
         .in_ready  (rot_ready[i]),
         .in_data   (rot_data[i]),
         .out_valid (rot_valid[i+1]),
         .out_ready (rot_ready[i+1]),
         .out_data  (rot_data[i+1])
      );
   end

   // ---------------------------------------------------------------------
   // Summing stage: add the rectangular vectors; a sum pointing left is
   // negated and the angle accumulator starts at half a turn.
   // ---------------------------------------------------------------------
   logic               sum_valid_ff;
   logic               sum_ready;
   pvadd_pkg::vec_type sum_ff;
   pvadd_pkg::vec_type sum_in;

   logic               vec_valid [0:CORDIC_STAGES];
   logic               vec_ready [0:CORDIC_STAGES];
   pvadd_pkg::vec_type vec_data  [0:CORDIC_STAGES];

   always_comb begin
      sum_in.x = rot_data[CORDIC_STAGES].x_a + rot_data[CORDIC_STAGES].x_b;
      sum_in.y = rot_data[CORDIC_STAGES].y_a + rot_data[CORDIC_STAGES].y_b;
      sum_in.z = '0;
      if (sum_in.x[XW-1]) begin
         sum_in.x = -sum_in.x;
         sum_in.y = -sum_in.y;
         sum_in.z = pvadd_pkg::HALF_TURN;
      end
   end

   assign sum_ready                = !sum_valid_ff || vec_ready[0];
   assign rot_ready[CORDIC_STAGES] = sum_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (sum_ready) begin
         sum_valid_ff <= rot_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && rot_valid[CORDIC_STAGES]) begin
         sum_ff <= sum_in;
      end
   end

   assign vec_valid[0] = sum_valid_ff;
   assign vec_data[0]  = sum_ff;

   // ---------------------------------------------------------------------
   // Vectoring chain: rotates the sum onto the x axis, collecting its angle.
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
      pvadd_vec_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vec_valid[i]),
         .in_ready  (vec_ready[i]),
         .in_data   (vec_data[i]),
         .out_valid (vec_valid[i+1]),
         .out_ready (vec_ready[i+1]),
         .out_data  (vec_data[i+1])
      );
   end

   // ---------------------------------------------------------------------
   // Multiply stage: x carries the square of the CORDIC gain, so it is
   // scaled by 2^32/A^2. The product is split into two partial products of
   // at most 18 by 31 bits. The angle is rounded half up to 16 bits here.
   // ---------------------------------------------------------------------
   logic        mul_valid_ff;
   logic        mul_ready;
   logic [47:0] mul_lo_ff;
   logic [48:0] mul_hi_ff;
   logic [15:0] mul_ang_ff;
   logic [34:0] mul_x;
   logic [31:0] ang_round;
   logic [47:0] mul_lo_in;
   logic [48:0] mul_hi_in;

   always_comb begin
      // Only a positive x contributes; the gain correction reads zero else.
      if (!vec_data[CORDIC_STAGES].x[XW-1] && (vec_data[CORDIC_STAGES].x != '0)) begin
         mul_x = vec_data[CORDIC_STAGES].x[34:0];
      end else begin
         mul_x = '0;
      end
      mul_lo_in = 48'(mul_x[16:0])  * 48'(pvadd_pkg::GAIN_COMP);
      mul_hi_in = 49'(mul_x[34:17]) * 49'(pvadd_pkg::GAIN_COMP);
      ang_round = vec_data[CORDIC_STAGES].z[31:0] + 32'h0000_8000;
   end

   assign mul_ready                = !mul_valid_ff || !rsp_valid || !rsp_stall;
   assign vec_ready[CORDIC_STAGES] = mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= vec_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && vec_valid[CORDIC_STAGES]) begin
         mul_lo_ff  <= mul_lo_in;
         mul_hi_ff  <= mul_hi_in;
         mul_ang_ff <= ang_round[31:16];
      end
   end

   // ---------------------------------------------------------------------
   // Output register: join the partial products, round off the low 46 bits,
   // clamp the length and force the angle of a null sum to zero.
   // ---------------------------------------------------------------------
   logic               out_valid_ff;
   logic               out_ready;
   pvadd_pkg::rsp_type out_ff;
   pvadd_pkg::rsp_type out_in;
   logic [66:0]        prod;
   logic [20:0]        len_full;

   always_comb begin
      prod     = {1'b0, mul_hi_ff, 17'b0} + 67'(mul_lo_ff) + (67'(1) << 45);
      len_full = prod[66:46];
      if (len_full > 21'(pvadd_pkg::LEN_MAX)) begin
         out_in.sum_length = pvadd_pkg::LEN_MAX;
      end else begin
         out_in.sum_length = len_full[16:0];
      end
      if (len_full == '0) begin
         out_in.sum_angle = '0;
      end else begin
         out_in.sum_angle = mul_ang_ff;
      end
   end

   assign out_ready = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && mul_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // A null sum never reports an angle.
   a_zero_angle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.sum_length == '0)) |-> (rsp_data.sum_angle == '0))
      else $error("non-zero angle on a zero-length beat");

   // A request stall implies full multiply and output stages and a stalled response.
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && mul_valid_ff))
      else $error("request stalled while the pipeline had room");

   // Nothing is presented in the cycle after reset.
   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule
